### rtl/cttc_pkg.sv
// Package with the shared types, sizes and command codes of the change-triggered trace capture unit.
package cttc_pkg;

    localparam int WATCHED_WORDS = 5;
    localparam int CAPACITY      = 4096;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int WSEL_W  = (WATCHED_WORDS > 1) ? $clog2(WATCHED_WORDS) : 1;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 2 * DATA_W;

    localparam logic [2:0] CMD_PRIME  = 3'd0;
    localparam logic [2:0] CMD_SAMPLE = 3'd1;
    localparam logic [2:0] CMD_ARM    = 3'd2;
    localparam logic [2:0] CMD_DISARM = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  word_index;
        logic [31:0] word_value;
        logic [31:0] timestamp;
        logic [11:0] read_index;
    } t_item;

    typedef struct packed {
        logic        changed;
        logic        stored;
        logic [12:0] entry_count;
        logic        armed;
        logic [31:0] read_value;
        logic [31:0] read_time;
    } t_result;

    typedef struct packed {
        logic load;
        logic exec;
        logic rd_done;
    } t_ctl;

    typedef struct packed {
        logic is_read;
    } t_sts;

endpackage

### rtl/cttc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module cttc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cttc_ctrl.sv
// Controller state machine that sequences each command through the datapath.
module cttc_ctrl
    import cttc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_busy,
    output logic o_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.is_read) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
                n_valid = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_ctl.load      = i_start && (r_state == ST_IDLE);
    assign o_ctl.exec      = (r_state == ST_EXEC);
    assign o_ctl.rd_done   = (r_state == ST_READ);

`ifndef ASSERT_OFF
    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("Result strobe raised while busy.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> o_busy)
        else $error("Accepted transfer did not make the block busy.");

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_ctl.exec && !i_sts.is_read) || $past(o_ctl.rd_done))
        else $error("Result strobe without a finished command.");
`endif

endmodule

### rtl/cttc_dp.sv
// Datapath holding the last-seen words, the fill count, the arm flag and the trace memory.
module cttc_dp
    import cttc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_ctl    i_ctl,
    output t_sts    o_sts,
    output t_result o_result
);

    t_item                r_item;
    logic [DATA_W-1:0]    r_last [WATCHED_WORDS];
    logic [COUNT_W-1:0]   r_fill, n_fill;
    logic                 r_armed, n_armed;
    logic                 r_rd_ok, n_rd_ok;
    t_result              r_result;

    logic                 word_ok;
    logic [WSEL_W-1:0]    wsel;
    logic                 diff;
    logic                 last_we;
    logic                 mem_we;
    logic                 changed;
    logic                 stored;
    logic [ENTRY_W-1:0]   rdata;

    assign wsel    = WSEL_W'(r_item.word_index);
    assign word_ok = (32'(r_item.word_index) < WATCHED_WORDS);
    assign diff    = (r_last[wsel] != r_item.word_value);

    always_comb begin
        n_fill  = r_fill;
        n_armed = r_armed;
        n_rd_ok = 1'b0;
        last_we = 1'b0;
        mem_we  = 1'b0;
        changed = 1'b0;
        stored  = 1'b0;
        case (r_item.cmd)
            CMD_PRIME: begin
                last_we = word_ok;
            end
            CMD_SAMPLE: begin
                if (r_armed && word_ok && diff) begin
                    changed = 1'b1;
                    last_we = 1'b1;
                    if (r_fill < COUNT_W'(CAPACITY)) begin
                        mem_we = 1'b1;
                        stored = 1'b1;
                        n_fill = r_fill + COUNT_W'(1);
                    end
                end
            end
            CMD_ARM: begin
                if (!r_armed) begin
                    n_fill  = '0;
                    n_armed = 1'b1;
                end
            end
            CMD_DISARM: begin
                n_armed = 1'b0;
            end
            CMD_READ: begin
                n_rd_ok = r_armed && (32'(r_item.read_index) < 32'(r_fill));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_item;
        end
        if (i_ctl.exec) begin
            r_rd_ok <= n_rd_ok;
        end
        if (i_ctl.exec && !o_sts.is_read) begin
            r_result.changed     <= changed;
            r_result.stored      <= stored;
            r_result.entry_count <= 13'(n_fill);
            r_result.armed       <= n_armed;
            r_result.read_value  <= '0;
            r_result.read_time   <= '0;
        end else if (i_ctl.rd_done) begin
            r_result.changed     <= 1'b0;
            r_result.stored      <= 1'b0;
            r_result.entry_count <= 13'(r_fill);
            r_result.armed       <= r_armed;
            r_result.read_value  <= r_rd_ok ? rdata[ENTRY_W-1:DATA_W] : '0;
            r_result.read_time   <= r_rd_ok ? rdata[DATA_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_armed <= 1'b0;
            for (int i = 0; i < WATCHED_WORDS; i++) begin
                r_last[i] <= '0;
            end
        end else if (i_ctl.exec) begin
            r_fill  <= n_fill;
            r_armed <= n_armed;
            for (int i = 0; i < WATCHED_WORDS; i++) begin
                if (last_we && (wsel == WSEL_W'(i))) begin
                    r_last[i] <= r_item.word_value;
                end
            end
        end
    end

    cttc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.exec && mem_we),
        .i_waddr(r_fill[ADDR_W-1:0]),
        .i_wdata({r_item.word_value, r_item.timestamp}),
        .i_re   (i_ctl.exec),
        .i_raddr(ADDR_W'(r_item.read_index)),
        .o_rdata(rdata)
    );

    assign o_sts.is_read = (r_item.cmd == CMD_READ);
    assign o_result      = r_result;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= COUNT_W'(CAPACITY))
        else $error("Fill count exceeds the buffer capacity.");

    a_store_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && mem_we) |-> (r_armed && changed))
        else $error("Trace memory written without an armed change.");
`endif

endmodule

### rtl/change_triggered_trace_capture_unit.sv
// Top level of the change-triggered trace capture unit.
// Usage: drive i_item and raise i_start; the command transfer happens at a rising
// edge where i_start is high and o_busy is low. Commands are prime, sample, arm,
// disarm and read entry. Each command returns exactly one result on o_result,
// marked by o_valid for a single cycle; the receiver cannot stall and must take
// it in that cycle.
// Sequencing: prime, sample, arm, disarm and unknown commands pass through the
// EXEC state, and o_busy is low again in the cycle that shows their result, so a
// new command is taken only once the last one is done. A read also passes through
// the READ state, needed by the registered read port of the trace memory.
// Reset (i_rst_n low, synchronous) disarms capture, clears the entry count and
// clears all last-seen words; trace memory contents are not cleared and only
// entries written since the last arm can be read back.
module change_triggered_trace_capture_unit
    import cttc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_result
);

    t_ctl ctl;
    t_sts sts;

    cttc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_sts  (sts),
        .o_ctl  (ctl),
        .o_busy (o_busy),
        .o_valid(o_valid)
    );

    cttc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_result(o_result)
    );

endmodule

### tb/sv/tb_change_triggered_trace_capture_unit.sv
// Self-checking testbench for the change-triggered trace capture unit.
module tb_change_triggered_trace_capture_unit
    import cttc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 1000;
    localparam int REPORT_CAP  = 100;

    typedef struct {
        t_result         res;
        longint unsigned acc_time;
    } t_pending;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    t_item   i_item;
    logic    o_busy;
    logic    o_valid;
    t_result o_result;

    logic [31:0]        last_seen [WATCHED_WORDS];
    logic [31:0]        value_log [CAPACITY];
    logic [31:0]        stamp_log [CAPACITY];
    logic [COUNT_W-1:0] fill_count;
    logic               capture_on;

    t_pending    trace_expect [$];
    t_pending    head;
    t_item       dir_item [$];
    bit          dir_typed [$];
    t_result     dir_want [$];
    int unsigned sender_idle_pct;
    logic [31:0] ts_clock;
    int unsigned err_count;
    int unsigned stall_cycles;
    int unsigned n_sent;
    int unsigned n_stored;
    int unsigned n_checked;

    change_triggered_trace_capture_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result trace_predict(input t_item it);
        t_result r;
        r = '0;
        case (it.cmd)
            CMD_PRIME: begin
                if (it.word_index < WATCHED_WORDS) last_seen[it.word_index] = it.word_value;
            end
            CMD_SAMPLE: begin
                if (capture_on && it.word_index < WATCHED_WORDS &&
                    it.word_value != last_seen[it.word_index]) begin
                    r.changed = 1'b1;
                    if (fill_count < CAPACITY) begin
                        value_log[fill_count[ADDR_W-1:0]] = it.word_value;
                        stamp_log[fill_count[ADDR_W-1:0]] = it.timestamp;
                        fill_count = fill_count + 1'b1;
                        r.stored = 1'b1;
                    end
                    last_seen[it.word_index] = it.word_value;
                end
            end
            CMD_ARM: begin
                if (!capture_on) begin
                    fill_count = '0;
                    capture_on = 1'b1;
                end
            end
            CMD_DISARM: begin
                capture_on = 1'b0;
            end
            CMD_READ: begin
                if (capture_on && it.read_index < fill_count) begin
                    r.read_value = value_log[it.read_index];
                    r.read_time  = stamp_log[it.read_index];
                end
            end
            default: begin
            end
        endcase
        r.entry_count = fill_count;
        r.armed       = capture_on;
        return r;
    endfunction

    function automatic t_item mk_item(input logic [2:0] cmd, input logic [2:0] widx,
                                      input logic [31:0] wval, input logic [31:0] ts,
                                      input logic [11:0] ridx);
        t_item it;
        it.cmd        = cmd;
        it.word_index = widx;
        it.word_value = wval;
        it.timestamp  = ts;
        it.read_index = ridx;
        return it;
    endfunction

    function automatic t_result mk_res(input bit ch, input bit st, input int cnt,
                                       input bit arm, input logic [31:0] rv,
                                       input logic [31:0] rt);
        t_result r;
        r.changed     = ch;
        r.stored      = st;
        r.entry_count = 13'(cnt);
        r.armed       = arm;
        r.read_value  = rv;
        r.read_time   = rt;
        return r;
    endfunction

    function automatic t_item rand_item();
        t_item       it;
        int unsigned pick;
        pick = $urandom_range(99);
        it.word_index = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                                 : 3'($urandom_range(WATCHED_WORDS - 1));
        it.word_value = $urandom;
        ts_clock = ts_clock + $urandom_range(1, 40);
        it.timestamp  = ($urandom_range(7) == 0) ? $urandom : ts_clock;
        it.read_index = 12'($urandom);
        if (pick < 48) begin
            it.cmd = CMD_SAMPLE;
            if (it.word_index < WATCHED_WORDS && $urandom_range(99) < 40) begin
                it.word_value = last_seen[it.word_index];
            end
        end else if (pick < 68) begin
            it.cmd = CMD_READ;
            if (fill_count != 0 && $urandom_range(3) != 0) begin
                it.read_index = 12'($urandom_range(fill_count - 1));
            end
        end else if (pick < 78) begin
            it.cmd = CMD_PRIME;
        end else if (pick < 88) begin
            it.cmd = CMD_ARM;
        end else if (pick < 93) begin
            it.cmd = CMD_DISARM;
        end else if (pick < 96) begin
            it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end else begin
            it.cmd        = CMD_PRIME;
            it.word_value = $urandom_range(1) ? '1 : '0;
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= REPORT_CAP) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        end
    endfunction

    task automatic add_row(input t_item it, input bit typed, input t_result want);
        dir_item.push_back(it);
        dir_typed.push_back(typed);
        dir_want.push_back(want);
    endtask

    task automatic send(input t_item it, input bit typed, input t_result want);
        t_result  model;
        t_pending p;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        model      = trace_predict(it);
        p.res      = typed ? want : model;
        p.acc_time = $time;
        trace_expect.push_back(p);
        n_sent++;
        n_stored += model.stored;
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (trace_expect.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int unsigned n_items, input int unsigned pct);
        t_item it;
        sender_idle_pct = pct;
        for (int unsigned k = 0; k < n_items; k++) begin
            it = rand_item();
            send(it, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (trace_expect.size() == 0 || trace_expect[0].acc_time == $time) begin
                err_count++;
                if (err_count <= REPORT_CAP) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, o_result);
                end
            end else begin
                head = trace_expect.pop_front();
                n_checked++;
                check_field("changed", 32'(head.res.changed), 32'(o_result.changed));
                check_field("stored", 32'(head.res.stored), 32'(o_result.stored));
                check_field("entry_count", 32'(head.res.entry_count),
                            32'(o_result.entry_count));
                check_field("armed", 32'(head.res.armed), 32'(o_result.armed));
                check_field("read_value", head.res.read_value, o_result.read_value);
                check_field("read_time", head.res.read_time, o_result.read_time);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("change_triggered_trace_capture_unit verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_item          = '0;
        fill_count      = '0;
        capture_on      = 1'b0;
        ts_clock        = '0;
        err_count       = 0;
        stall_cycles    = 0;
        n_sent          = 0;
        n_stored        = 0;
        n_checked       = 0;
        sender_idle_pct = 34;
        foreach (last_seen[k]) last_seen[k] = '0;

        add_row(mk_item(CMD_READ, '0, '0, '0, '0), 1, mk_res(0, 0, 0, 0, 0, 0));
        add_row(mk_item(CMD_SAMPLE, 3'd0, '1, '1, '0), 1, mk_res(0, 0, 0, 0, 0, 0));
        add_row(mk_item(CMD_ARM, '0, '0, '0, '0), 1, mk_res(0, 0, 0, 1, 0, 0));
        add_row(mk_item(CMD_SAMPLE, 3'd0, '0, '0, '1), 1, mk_res(0, 0, 0, 1, 0, 0));
        add_row(mk_item(CMD_PRIME, 3'd4, '1, '0, '0), 1, mk_res(0, 0, 0, 1, 0, 0));
        add_row(mk_item(CMD_SAMPLE, 3'd4, '1, '0, '0), 1, mk_res(0, 0, 0, 1, 0, 0));
        add_row(mk_item(CMD_SAMPLE, 3'd4, '0, '1, '0), 1, mk_res(1, 1, 1, 1, 0, 0));
        add_row(mk_item(CMD_SAMPLE, 3'd0, 32'h8000_0001, 32'h5555_AAAA, '0), 1,
                mk_res(1, 1, 2, 1, 0, 0));
        add_row(mk_item(CMD_READ, '0, '0, '0, 12'd0), 1, mk_res(0, 0, 2, 1, 0, '1));
        add_row(mk_item(CMD_READ, '0, '0, '0, 12'd1), 1,
                mk_res(0, 0, 2, 1, 32'h8000_0001, 32'h5555_AAAA));
        add_row(mk_item(CMD_READ, '0, '0, '0, 12'd2), 1, mk_res(0, 0, 2, 1, 0, 0));
        add_row(mk_item(CMD_READ, '1, '1, '1, '1), 1, mk_res(0, 0, 2, 1, 0, 0));
        add_row(mk_item(CMD_SAMPLE, 3'd7, 32'h1234, '1, '0), 1, mk_res(0, 0, 2, 1, 0, 0));
        add_row(mk_item(CMD_PRIME, 3'd5, 32'h1, '0, '0), 1, mk_res(0, 0, 2, 1, 0, 0));
        add_row(mk_item(CMD_SAMPLE, 3'd5, '1, '0, '0), 1, mk_res(0, 0, 2, 1, 0, 0));
        add_row(mk_item(CMD_SPARE_LO, 3'd1, '1, '1, '0), 1, mk_res(0, 0, 2, 1, 0, 0));
        add_row(mk_item(3'(CMD_SPARE_LO + 1), 3'd2, '1, '1, '0), 1,
                mk_res(0, 0, 2, 1, 0, 0));
        add_row(mk_item(CMD_SPARE_HI, 3'd3, '1, '1, '0), 1, mk_res(0, 0, 2, 1, 0, 0));
        add_row(mk_item(CMD_ARM, '0, '0, '0, '0), 1, mk_res(0, 0, 2, 1, 0, 0));
        add_row(mk_item(CMD_DISARM, '0, '0, '0, '0), 1, mk_res(0, 0, 2, 0, 0, 0));
        add_row(mk_item(CMD_READ, '0, '0, '0, 12'd0), 1, mk_res(0, 0, 2, 0, 0, 0));
        add_row(mk_item(CMD_SAMPLE, 3'd4, 32'h1234, '0, '0), 1, mk_res(0, 0, 2, 0, 0, 0));
        add_row(mk_item(CMD_ARM, '0, '0, '0, '0), 1, mk_res(0, 0, 0, 1, 0, 0));
        add_row(mk_item(CMD_SAMPLE, 3'd4, '0, '0, '0), 1, mk_res(0, 0, 0, 1, 0, 0));
        add_row(mk_item(CMD_SAMPLE, 3'd1, 32'h1, 32'h7, '0), 1, mk_res(1, 1, 1, 1, 0, 0));
        add_row(mk_item(CMD_READ, '0, '0, '0, 12'd0), 1, mk_res(0, 0, 1, 1, 32'h1, 32'h7));
        add_row(mk_item(CMD_SAMPLE, 3'd2, $urandom, $urandom, '0), 0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_item[k]) send(dir_item[k], dir_typed[k], dir_want[k]);
        run_random(310, 34);
        drain();
        run_random(310, 64);
        drain();
        run_random(300, 0);
        drain();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d transfers of every command kind, with %0d captured changes;",
                 n_sent, n_stored);
        $display("%0d results checked, %0d mismatches.", n_checked, err_count);
        if (err_count == 0 && trace_expect.size() == 0) begin
            $display("change_triggered_trace_capture_unit verification clean");
        end else begin
            $display("change_triggered_trace_capture_unit verification failed");
        end
        $finish;
    end

endmodule
